FILE: hw/rtl/tljf_pkg.sv
// Package for the truncated Lennard-Jones force accumulator.
// Holds field widths, register indexes, sequencer codes and the
// controller/datapath command structs. No dependencies.
package tljf_pkg;

  localparam int DIST_W    = 26;
  localparam int DELTA_W   = 28;
  localparam int COEF_W    = 32;
  localparam int FORCE_W   = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 64;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int QUO_W     = 41;
  localparam int DCNT_W    = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TSS    = 2'd2;

  localparam logic [DIST_W-1:0] CUTOFF_RST = 26'd1048576;
  localparam logic [COEF_W-1:0] COEF_RST   = 32'd19660800;
  localparam logic [DIST_W-1:0] TSS_RST    = 26'd1048576;

  // 1/r is floor(2^40 / r): one quotient bit per dividend bit 40..0.
  localparam logic [DCNT_W-1:0] DIV_TOP = 6'd40;
  localparam logic [WORD_W-1:0] ONE_Q20 = 64'd1048576;

  localparam logic [FORCE_W-1:0] POS_LIM = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic [FORCE_W-1:0] NEG_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_DIV, S_MUL, S_ACC, S_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_INV2, OP_INV4, OP_INV6, OP_INV8, OP_P, OP_M1, OP_M2, OP_X, OP_Y, OP_Z
  } mul_op_e;

  typedef struct packed {
    logic    latch;
    logic    div_run;
    logic    mul_run;
    mul_op_e mul_op;
    logic    set_flag;
    logic    acc_add;
    logic    emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic skip;
    logic r_zero;
    logic last;
    logic div_done;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/tljf_if.sv
// Valid/ready channel interfaces: pair words in, force words out.
// Depends on tljf_pkg for field widths.
interface tljf_pair_if;
  import tljf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [DIST_W-1:0]         pair_distance;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [DELTA_W-1:0] delta_z;
  logic                      is_self;
  logic                      last_pair;
  modport source(output valid, pair_distance, delta_x, delta_y, delta_z, is_self,
                 last_pair, input ready);
  modport sink(input valid, pair_distance, delta_x, delta_y, delta_z, is_self,
               last_pair, output ready);
endinterface

interface tljf_force_if;
  import tljf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FORCE_W-1:0] force_x;
  logic signed [FORCE_W-1:0] force_y;
  logic signed [FORCE_W-1:0] force_z;
  logic                      saturated;
  modport source(output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink(input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

FILE: hw/rtl/tljf_ctrl.sv
// Sequencer for the force accumulator: walks check, divide, the multiply
// chain, accumulate and emit. Depends on tljf_pkg.
module tljf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tljf_pkg::dp_status_t  sts_i,
  output tljf_pkg::ctl_cmd_t    cmd_o
);
  import tljf_pkg::*;

  state_e  state_q, state_d;
  mul_op_e op_q, op_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INV2;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.mul_op = op_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.skip) begin
          state_d = S_EMIT;
        end else if (sts_i.r_zero) begin
          // Zero distance inside the cutoff has no direction.
          cmd_o.set_flag = 1'b1;
          state_d        = S_EMIT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_done) begin
          op_d    = OP_INV2;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_run = 1'b1;
        if (sts_i.mul_done) begin
          if (op_q == OP_Z) begin
            state_d = S_ACC;
          end else begin
            op_d = mul_op_e'(op_q + 4'd1);
          end
        end
      end
      S_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/tljf_datapath.sv
// Datapath: configuration registers, radix-2 divider for 1/r, one shared
// 32x32 multiplier for the power chain, saturating sums and the output word.
// Depends on tljf_pkg and tljf_force_if.
module tljf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tljf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tljf_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic [tljf_pkg::DIST_W-1:0]         pair_distance_i,
  input  logic signed [tljf_pkg::DELTA_W-1:0] delta_x_i,
  input  logic signed [tljf_pkg::DELTA_W-1:0] delta_y_i,
  input  logic signed [tljf_pkg::DELTA_W-1:0] delta_z_i,
  input  logic                                is_self_i,
  input  logic                                last_pair_i,
  input  tljf_pkg::ctl_cmd_t                  cmd_i,
  output tljf_pkg::dp_status_t                sts_o,
  tljf_force_if.source                        force_o
);
  import tljf_pkg::*;

  function automatic logic [WORD_W-1:0] abs_delta(input logic [DELTA_W-1:0] d);
    logic [DELTA_W-1:0] m;
    m = d[DELTA_W-1] ? (~d + 1'b1) : d;
    return {{(WORD_W-DELTA_W){1'b0}}, m};
  endfunction

  // Returns {clamped, term}: signed term with the limits applied.
  function automatic logic [FORCE_W:0] axis_term(input logic [WORD_W-1:0] mag,
                                                 input logic dneg, input logic bneg);
    logic [WORD_W-1:0] lim;
    logic              clamp;
    logic [FORCE_W-1:0] t;
    clamp = 1'b0;
    t     = '0;
    if (mag != '0) begin
      if (dneg == bneg) begin
        lim = {{(WORD_W-FORCE_W){1'b0}}, NEG_LIM};
        if (mag > lim) begin
          clamp = 1'b1;
          t     = NEG_LIM;
        end else begin
          t = ~mag[FORCE_W-1:0] + 1'b1;
        end
      end else begin
        lim = {{(WORD_W-FORCE_W){1'b0}}, POS_LIM};
        if (mag > lim) begin
          clamp = 1'b1;
          t     = POS_LIM;
        end else begin
          t = mag[FORCE_W-1:0];
        end
      end
    end
    return {clamp, t};
  endfunction

  // Returns {clamped, sum}.
  function automatic logic [FORCE_W:0] add_clamp(input logic [FORCE_W-1:0] a,
                                                 input logic [FORCE_W-1:0] b);
    logic [FORCE_W:0] s;
    s = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
    if (s[FORCE_W] != s[FORCE_W-1]) begin
      return {1'b1, s[FORCE_W] ? NEG_LIM : POS_LIM};
    end
    return {1'b0, s[FORCE_W-1:0]};
  endfunction

  logic [DIST_W-1:0]  cutoff_q, tss_q;
  logic [COEF_W-1:0]  coef_q;
  logic [DIST_W-1:0]  r_q;
  logic [DELTA_W-1:0] dx_q, dy_q, dz_q;
  logic               self_q, last_q;

  logic [DIST_W:0]    rem_q, rem_sh, rem_d;
  logic [QUO_W-1:0]   quo_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic               div_ge;

  logic [WORD_W-1:0]  inv2_q, inv4_q, inv6_q, inv8_q, b_q, m1_q, m2_q;
  logic               bneg_q;
  logic [FORCE_W-1:0] tx_q, ty_q, tz_q;
  logic [FORCE_W-1:0] sx_q, sy_q, sz_q;
  logic               flag_q;

  logic [2:0]         mcnt_q;
  logic [PROD_W-1:0]  prod_q, prod_d, pp_sh;
  logic [WORD_W-1:0]  op_a, op_b, pp, res, p_val;
  logic [31:0]        a_h, b_h;
  logic               sat, mul_done, clamp;
  logic [FORCE_W:0]   term, ax, ay, az;
  logic               axis_op, dsign;
  logic [WORD_W-1:0]  dmag;

  logic               out_valid_q, out_sat_q;
  logic [FORCE_W-1:0] out_x_q, out_y_q, out_z_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= CUTOFF_RST;
      coef_q   <= COEF_RST;
      tss_q    <= TSS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CUTOFF) cutoff_q <= cfg_data_i[DIST_W-1:0];
      if (cfg_idx_i == CFG_COEF)   coef_q   <= cfg_data_i[COEF_W-1:0];
      if (cfg_idx_i == CFG_TSS)    tss_q    <= cfg_data_i[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      r_q    <= pair_distance_i;
      dx_q   <= delta_x_i;
      dy_q   <= delta_y_i;
      dz_q   <= delta_z_i;
      self_q <= is_self_i;
      last_q <= last_pair_i;
    end
  end

  // Restoring divider: 2^40 / r, one quotient bit per cycle.
  always_comb begin
    rem_sh = {rem_q[DIST_W-1:0], (dcnt_q == DIV_TOP)};
    div_ge = rem_sh >= {1'b0, r_q};
    rem_d  = div_ge ? (rem_sh - {1'b0, r_q}) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      rem_q  <= '0;
      quo_q  <= '0;
      dcnt_q <= DIV_TOP;
    end else if (cmd_i.div_run) begin
      rem_q  <= rem_d;
      quo_q  <= {quo_q[QUO_W-2:0], div_ge};
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      OP_INV2: begin
        op_a = {{(WORD_W-QUO_W){1'b0}}, quo_q};
        op_b = {{(WORD_W-QUO_W){1'b0}}, quo_q};
      end
      OP_INV4: begin op_a = inv2_q; op_b = inv2_q; end
      OP_INV6: begin op_a = inv4_q; op_b = inv2_q; end
      OP_INV8: begin op_a = inv4_q; op_b = inv4_q; end
      OP_P:    begin op_a = {{(WORD_W-DIST_W){1'b0}}, tss_q}; op_b = inv6_q; end
      OP_M1:   begin op_a = inv8_q; op_b = b_q; end
      OP_M2:   begin op_a = m1_q; op_b = {{(WORD_W-COEF_W){1'b0}}, coef_q}; end
      OP_X:    begin op_a = m2_q; op_b = abs_delta(dx_q); end
      OP_Y:    begin op_a = m2_q; op_b = abs_delta(dy_q); end
      OP_Z:    begin op_a = m2_q; op_b = abs_delta(dz_q); end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Four partial products are summed into prod_q, then the product is written back.
  always_comb begin
    a_h = mcnt_q[1] ? op_a[WORD_W-1:32] : op_a[31:0];
    b_h = mcnt_q[0] ? op_b[WORD_W-1:32] : op_b[31:0];
    pp  = {32'd0, a_h} * {32'd0, b_h};
    case (mcnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    prod_d = (mcnt_q == 3'd0) ? pp_sh : (prod_q + pp_sh);
  end

  assign mul_done = cmd_i.mul_run && (mcnt_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q <= '0;
    end else if (cmd_i.mul_run) begin
      mcnt_q <= (mcnt_q == 3'd4) ? 3'd0 : (mcnt_q + 3'd1);
    end else begin
      mcnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_run && (mcnt_q != 3'd4)) prod_q <= prod_d;
  end

  // Shift and saturate the finished product.
  always_comb begin
    case (cmd_i.mul_op)
      OP_M2: begin
        sat = |prod_q[PROD_W-1:80];
        res = prod_q[79:16];
      end
      OP_X, OP_Y, OP_Z: begin
        sat = |prod_q[PROD_W-1:88];
        res = prod_q[87:24];
      end
      default: begin
        sat = |prod_q[PROD_W-1:84];
        res = prod_q[83:20];
      end
    endcase
    if (sat) res = '1;
    p_val = res;
    axis_op = (cmd_i.mul_op == OP_X) || (cmd_i.mul_op == OP_Y) ||
              (cmd_i.mul_op == OP_Z);
    case (cmd_i.mul_op)
      OP_Y:    dsign = dy_q[DELTA_W-1];
      OP_Z:    dsign = dz_q[DELTA_W-1];
      default: dsign = dx_q[DELTA_W-1];
    endcase
    dmag  = res;
    term  = axis_term(dmag, dsign, bneg_q);
    clamp = axis_op && term[FORCE_W];
  end

  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      case (cmd_i.mul_op)
        OP_INV2: inv2_q <= res;
        OP_INV4: inv4_q <= res;
        OP_INV6: inv6_q <= res;
        OP_INV8: inv8_q <= res;
        OP_P: begin
          bneg_q <= p_val > ONE_Q20;
          b_q    <= (p_val > ONE_Q20) ? (p_val - ONE_Q20) : (ONE_Q20 - p_val);
        end
        OP_M1:   m1_q <= res;
        OP_M2:   m2_q <= res;
        OP_X:    tx_q <= term[FORCE_W-1:0];
        OP_Y:    ty_q <= term[FORCE_W-1:0];
        OP_Z:    tz_q <= term[FORCE_W-1:0];
        default: m2_q <= m2_q;
      endcase
    end
  end

  assign ax = add_clamp(sx_q, tx_q);
  assign ay = add_clamp(sy_q, ty_q);
  assign az = add_clamp(sz_q, tz_q);

  // Sums, saturation flag and output word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q        <= '0;
      sy_q        <= '0;
      sz_q        <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        sx_q        <= '0;
        sy_q        <= '0;
        sz_q        <= '0;
        flag_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        if (force_o.ready) out_valid_q <= 1'b0;
        if (cmd_i.acc_add) begin
          sx_q <= ax[FORCE_W-1:0];
          sy_q <= ay[FORCE_W-1:0];
          sz_q <= az[FORCE_W-1:0];
        end
        if (cmd_i.set_flag || (mul_done && (sat || clamp)) ||
            (cmd_i.acc_add && (ax[FORCE_W] || ay[FORCE_W] || az[FORCE_W]))) begin
          flag_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_x_q   <= sx_q;
      out_y_q   <= sy_q;
      out_z_q   <= sz_q;
      out_sat_q <= flag_q;
    end
  end

  assign force_o.valid     = out_valid_q;
  assign force_o.force_x   = out_x_q;
  assign force_o.force_y   = out_y_q;
  assign force_o.force_z   = out_z_q;
  assign force_o.saturated = out_sat_q;

  assign sts_o.skip     = self_q || (r_q >= cutoff_q);
  assign sts_o.r_zero   = (r_q == '0);
  assign sts_o.last     = last_q;
  assign sts_o.div_done = cmd_i.div_run && (dcnt_q == '0);
  assign sts_o.mul_done = mul_done;
  assign sts_o.out_free = !out_valid_q || force_o.ready;

endmodule

FILE: hw/rtl/truncated_lj_force_accumulator.sv
// Top level of the truncated Lennard-Jones force accumulator.
// Depends on tljf_pkg, tljf_if, tljf_ctrl and tljf_datapath.
//
//   channel   | dir | word                                         | handshake
//   ----------+-----+----------------------------------------------+-----------
//   pair_i    | in  | distance, delta x/y/z, self mark, last mark  | valid/ready
//   force_o   | out | force x/y/z sums, saturated flag             | valid/ready
//   cfg       | in  | register index, data                         | cfg_we_i
//
// A self pair, a pair at or beyond the cutoff, or one with zero distance
// goes from the check straight to emit. A pair inside the cutoff runs the
// bit-serial divider that forms 1/r, then the ten products on the shared
// 32x32 multiplier. Reset clears the sums, the flag, the sequencer and
// restores the register defaults. A stalled result word sits in the output
// register; the block only waits on it when a further last pair must emit.
module truncated_lj_force_accumulator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tljf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tljf_pkg::CFG_W-1:0]     cfg_data_i,
  tljf_pair_if.sink                      pair_i,
  tljf_force_if.source                   force_o
);
  import tljf_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t sts;
  logic       in_ready;

  // The sequencer takes one pair at a time.
  assign pair_i.ready = in_ready;

  tljf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pair_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tljf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pair_distance_i (pair_i.pair_distance),
    .delta_x_i       (pair_i.delta_x),
    .delta_y_i       (pair_i.delta_y),
    .delta_z_i       (pair_i.delta_z),
    .is_self_i       (pair_i.is_self),
    .last_pair_i     (pair_i.last_pair),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .force_o         (force_o)
  );

endmodule

FILE: hw/rtl/tljf_checker.sv
// Port-level checks for the force accumulator, bound to the top level.
// Depends on tljf_pkg for widths.
module tljf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          pair_valid_i,
  input logic                          pair_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [tljf_pkg::FORCE_W-1:0]  out_x_i,
  input logic                          out_sat_i
);
  import tljf_pkg::*;

  // A waiting result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) && $stable(out_sat_i))
    else $error("result word changed while stalled");

  // One pair at a time: ready drops after an accept.
  a_one_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_i && pair_ready_i |=> !pair_ready_i)
    else $error("second pair taken while busy");

  // A new result only appears while the block is working on a pair.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!pair_ready_i))
    else $error("result appeared while idle");

endmodule

bind truncated_lj_force_accumulator tljf_checker u_tljf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pair_valid_i (pair_i.valid),
  .pair_ready_i (pair_i.ready),
  .out_valid_i  (force_o.valid),
  .out_ready_i  (force_o.ready),
  .out_x_i      (force_o.force_x),
  .out_sat_i    (force_o.saturated)
);
